FILE: rtl/assert_macros.svh
// Assertion macros shared by the video memory access gate RTL.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication or sequence property.
`define VMAG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition never holds.
`define VMAG_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: rtl/vmag_pkg.sv
// Package of the video memory access gate: types, codes, timing constants and the sprite address fold.
// Used by vmag_gate, video_memory_access_gate and the testbench; depends on nothing.
package vmag_pkg;

   localparam int VRAM_BYTES_DEF    = 65536;
   localparam int SPRITE_BYTES_DEF  = 544;
   localparam int PALETTE_BYTES_DEF = 512;

   localparam int VRAM_AW = 16;
   localparam int SPR_AW  = 10;
   localparam int PAL_AW  = 9;

   localparam int LINES_NTSC = 525;
   localparam int LINES_PAL  = 625;

   localparam logic [10:0] DOT_LAST    = 11'd1362;
   localparam logic [10:0] DOT_EARLY   = 11'd4;
   localparam logic [10:0] DOT_LATCH   = 11'd6;
   localparam logic [8:0]  LAST_NTSC   = 9'((LINES_NTSC >> 1) - 1);
   localparam logic [8:0]  LAST_PAL    = 9'((LINES_PAL >> 1) - 1);
   localparam logic [8:0]  VIS_RD_STD  = 9'd224;
   localparam logic [8:0]  VIS_RD_OVR  = 9'd239;
   localparam logic [8:0]  VIS_WR_STD  = 9'd225;
   localparam logic [8:0]  VIS_WR_OVR  = 9'd240;
   localparam logic [9:0]  SPR_WRAP    = 10'h3ff;
   localparam logic [9:0]  SPR_HIGH    = 10'h200;
   localparam logic [9:0]  SPR_HIGH_MASK = 10'h21f;
   localparam logic [8:0]  PAL_WRAP    = 9'h1ff;
   localparam logic [7:0]  PAL_ODD_MASK = 8'h7f;

   typedef enum logic [2:0] {
      CMD_VRAM_RD  = 3'd0,
      CMD_VRAM_WR  = 3'd1,
      CMD_SPR_RD   = 3'd2,
      CMD_SPR_WR   = 3'd3,
      CMD_PAL_RD   = 3'd4,
      CMD_PAL_WR   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_DISPLAY_OFF   = 2'd0,
      CSR_OVERSCAN_MODE = 2'd1,
      CSR_PAL_REGION    = 2'd2,
      CSR_INTERLACE_ON  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MEM_NONE    = 2'd0,
      MEM_VRAM    = 2'd1,
      MEM_SPRITE  = 2'd2,
      MEM_PALETTE = 2'd3
   } mem_sel_type;

   typedef struct packed {
      logic display_off;
      logic overscan_mode;
      logic pal_region;
      logic interlace_on;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [8:0]  line_count;
      logic [10:0] dot_count;
      logic        odd_field;
      logic [7:0]  bus_latch;
      logic [9:0]  sprite_index;
   } req_type;

   typedef struct packed {
      mem_sel_type         sel;
      logic                we;
      logic [VRAM_AW-1:0]  vram_index;
      logic [SPR_AW-1:0]   spr_addr;
      logic [PAL_AW-1:0]   pal_addr;
      logic [7:0]          wdata;
      logic                pal_mask;
      logic                taken;
   } access_type;

   function automatic logic [SPR_AW-1:0] fold_sprite(input logic [SPR_AW-1:0] a);
      logic [SPR_AW-1:0] f;
      f = a & SPR_WRAP;
      if ((f & SPR_HIGH) != '0) begin
         f = f & SPR_HIGH_MASK;
      end
      return f;
   endfunction

endpackage

FILE: rtl/vmag_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Used for every video memory; depends on nothing.
module vmag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/vmag_gate.sv
// Access decision for one CPU request: memory select, address, data and read and write gating.
// Depends on vmag_pkg.
module vmag_gate (
   input  vmag_pkg::cfg_type    cfg,
   input  vmag_pkg::req_type    req,
   output vmag_pkg::access_type acc
);
   import vmag_pkg::*;

   logic       on;
   logic       active;
   logic [8:0] vis_rd;
   logic [8:0] vis_wr;
   logic [8:0] last_line;
   logic       vram_rd_ok;
   logic [SPR_AW-1:0] spr_src;

   always_comb begin
      on        = !cfg.display_off;
      vis_rd    = cfg.overscan_mode ? VIS_RD_OVR : VIS_RD_STD;
      vis_wr    = cfg.overscan_mode ? VIS_WR_OVR : VIS_WR_STD;
      last_line = (cfg.pal_region ? LAST_PAL : LAST_NTSC)
                + {8'd0, cfg.interlace_on && !req.odd_field};
      active    = on && (req.line_count < vis_wr);
      spr_src   = active ? req.sprite_index : req.address[SPR_AW-1:0];

      if (!on) begin
         vram_rd_ok = 1'b1;
      end else if (req.line_count == last_line && req.dot_count == DOT_LAST) begin
         vram_rd_ok = 1'b0;
      end else if (req.line_count < vis_rd) begin
         vram_rd_ok = 1'b0;
      end else if (req.line_count == vis_rd) begin
         vram_rd_ok = (req.dot_count == DOT_LAST);
      end else begin
         vram_rd_ok = 1'b1;
      end

      acc            = '0;
      acc.sel        = MEM_NONE;
      acc.vram_index = req.address[VRAM_AW-1:0];
      acc.spr_addr   = fold_sprite(spr_src);
      acc.pal_addr   = req.address[PAL_AW-1:0] & PAL_WRAP;
      acc.wdata      = req.write_data;
      acc.pal_mask   = acc.pal_addr[0];

      case (req.command)
         CMD_VRAM_RD: begin
            if (vram_rd_ok) begin
               acc.sel = MEM_VRAM;
            end
         end
         CMD_VRAM_WR: begin
            acc.we = 1'b1;
            if (!on) begin
               acc.sel = MEM_VRAM;
            end else if (req.line_count == 9'd0) begin
               if (req.dot_count <= DOT_EARLY) begin
                  acc.sel = MEM_VRAM;
               end else if (req.dot_count == DOT_LATCH) begin
                  acc.sel   = MEM_VRAM;
                  acc.wdata = req.bus_latch;
               end
            end else if (req.line_count < vis_wr) begin
               acc.sel = MEM_NONE;
            end else if (req.line_count == vis_wr) begin
               if (req.dot_count > DOT_EARLY) begin
                  acc.sel = MEM_VRAM;
               end
            end else begin
               acc.sel = MEM_VRAM;
            end
            acc.taken = (acc.sel == MEM_VRAM);
         end
         CMD_SPR_RD: begin
            acc.sel = MEM_SPRITE;
         end
         CMD_SPR_WR: begin
            acc.sel   = MEM_SPRITE;
            acc.we    = 1'b1;
            acc.taken = 1'b1;
         end
         CMD_PAL_RD: begin
            acc.sel = MEM_PALETTE;
         end
         CMD_PAL_WR: begin
            acc.sel   = MEM_PALETTE;
            acc.we    = 1'b1;
            acc.taken = 1'b1;
            if (acc.pal_mask) begin
               acc.wdata = req.write_data & PAL_ODD_MASK;
            end
         end
         default: begin
            acc.sel = MEM_NONE;
         end
      endcase
   end

endmodule

FILE: rtl/video_memory_access_gate.sv
// Video memory access gate: CPU access to VRAM, sprite table and palette RAM.
// Channels: req_ carries one CPU request with the beam position, rsp_ returns
// one result per request, csr_ writes the four display settings.
// A request is accepted when req_tvalid and req_tready are both high: the memory is
// read at the accepting edge and the result is loaded into the output register when
// that register is free; one request per cycle is sustained while the receiver does
// not stall, set by the single memory port that each request uses.
// Reads go through a memory stage and then the output register, so a
// request is accepted whenever the memory stage is empty or can advance.
// When the receiver stalls, the result holds in the output register, the
// memory stage holds behind it and req_tready drops once that stage is full.
// Reset clears the pipeline valid flags and sets display_off to one with the
// other settings at zero; the memories keep their contents and need no clear.
// The user must write settings only while no request is in flight; the block does not enforce it.
// Depends on vmag_pkg, vmag_gate, vmag_ram and assert_macros.svh.
`include "assert_macros.svh"
module video_memory_access_gate #(
   parameter int VRAM_BYTES    = vmag_pkg::VRAM_BYTES_DEF,
   parameter int SPRITE_BYTES  = vmag_pkg::SPRITE_BYTES_DEF,
   parameter int PALETTE_BYTES = vmag_pkg::PALETTE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // address[15:0], write_data[23:16], line_count[32:24], dot_count[43:33],
   // odd_field[44], bus_latch[52:45], sprite_index[62:53]
   input  logic [63:0] req_tdata,
   // command[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0]
   output logic [7:0]  rsp_tdata,
   // write_taken[0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic        csr_data
);
   import vmag_pkg::*;

   localparam int VramAw = $clog2(VRAM_BYTES);
   localparam int SprAw  = $clog2(SPRITE_BYTES);
   localparam int PalAw  = $clog2(PALETTE_BYTES);

   cfg_type     cfg_ff, cfg_in;
   req_type     req;
   access_type  acc;
   logic        req_accept;
   logic        out_free;
   logic        vram_en, spr_en, pal_en;
   logic [7:0]  vram_rdata, spr_rdata, pal_rdata;

   logic        s1_valid_ff, s1_valid_in;
   mem_sel_type s1_kind_ff, s1_kind_in;
   logic        s1_mask_ff, s1_mask_in;
   logic        s1_taken_ff, s1_taken_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_taken_ff, rsp_taken_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DISPLAY_OFF:   cfg_in.display_off   = csr_data;
            CSR_OVERSCAN_MODE: cfg_in.overscan_mode = csr_data;
            CSR_PAL_REGION:    cfg_in.pal_region    = csr_data;
            CSR_INTERLACE_ON:  cfg_in.interlace_on  = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      req.command      = req_tuser;
      req.address      = req_tdata[15:0];
      req.write_data   = req_tdata[23:16];
      req.line_count   = req_tdata[32:24];
      req.dot_count    = req_tdata[43:33];
      req.odd_field    = req_tdata[44];
      req.bus_latch    = req_tdata[52:45];
      req.sprite_index = req_tdata[62:53];
   end

   vmag_gate u_gate (
      .cfg (cfg_ff),
      .req (req),
      .acc (acc)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   assign vram_en = req_accept && (acc.sel == MEM_VRAM);
   assign spr_en  = req_accept && (acc.sel == MEM_SPRITE);
   assign pal_en  = req_accept && (acc.sel == MEM_PALETTE);

   vmag_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_vram (
      .clock (clock),
      .en    (vram_en),
      .we    (acc.we),
      .addr  (acc.vram_index[VramAw-1:0]),
      .wdata (acc.wdata),
      .rdata (vram_rdata)
   );

   vmag_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_sprite (
      .clock (clock),
      .en    (spr_en),
      .we    (acc.we),
      .addr  (acc.spr_addr[SprAw-1:0]),
      .wdata (acc.wdata),
      .rdata (spr_rdata)
   );

   vmag_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_palette (
      .clock (clock),
      .en    (pal_en),
      .we    (acc.we),
      .addr  (acc.pal_addr[PalAw-1:0]),
      .wdata (acc.wdata),
      .rdata (pal_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_mask_in  = s1_mask_ff;
      s1_taken_in = s1_taken_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = acc.we ? MEM_NONE : acc.sel;
         s1_mask_in  = acc.pal_mask;
         s1_taken_in = acc.taken;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_taken_in = rsp_taken_ff;
      if (s1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_taken_in = s1_taken_ff;
         case (s1_kind_ff)
            MEM_VRAM:    rsp_data_in = vram_rdata;
            MEM_SPRITE:  rsp_data_in = spr_rdata;
            MEM_PALETTE: rsp_data_in = s1_mask_ff ? (pal_rdata & PAL_ODD_MASK) : pal_rdata;
            default:     rsp_data_in = 8'd0;
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{display_off: 1'b1, overscan_mode: 1'b0,
                           pal_region: 1'b0, interlace_on: 1'b0};
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff   <= s1_kind_in;
      s1_mask_ff   <= s1_mask_in;
      s1_taken_ff  <= s1_taken_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_taken_ff <= rsp_taken_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_taken_ff;

   `VMAG_ASSERT(a_accept_fills_stage, req_accept |=> s1_valid_ff, "accepted request lost")
   `VMAG_ASSERT(a_stall_holds_stage, (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_kind_ff)), "memory stage changed while stalled")
   `VMAG_ASSERT(a_one_memory, $onehot0({vram_en, spr_en, pal_en}), "more than one memory enabled")
   `VMAG_NEVER(a_write_reads_zero, rsp_valid_ff && rsp_taken_ff && (rsp_data_ff != 8'd0), "taken write returned read data")

endmodule

FILE: tb/tb_video_memory_access_gate.sv
// Self-checking testbench for video_memory_access_gate: predicts each response from
// its own model of the three memories and the display settings. Depends on vmag_pkg.
// Directed cases come first, then random requests under several display settings.
`timescale 1ns / 100ps
module tb_video_memory_access_gate;
   import vmag_pkg::*;

   localparam int STALL_LIMIT    = 2000;
   localparam int SQUEEZE_CYCLES = 200;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 190;

   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   localparam logic [8:0]  EDGE_LINES [14] = '{9'd0, 9'd1, 9'd223, 9'd224, 9'd225, 9'd226,
      9'd238, 9'd239, 9'd240, 9'd241, 9'd261, 9'd262, 9'd311, 9'd312};
   localparam logic [10:0] EDGE_DOTS [9] = '{11'd0, 11'd3, 11'd4, 11'd5, 11'd6, 11'd7,
      11'd1361, 11'd1362, 11'd1363};

   // Bit order of each entry: display_off, overscan_mode, pal_region, interlace_on.
   localparam cfg_type SETTING_PLAN [8] = '{4'b0100, 4'b0010, 4'b0001, 4'b0111,
      4'b1111, 4'b0011, 4'b0101, 4'b0110};

   typedef struct packed {
      logic [7:0] read_data;
      logic       write_taken;
   } gate_result_type;

   typedef struct {
      mem_sel_type target;
      int unsigned slot;
      bit          is_store;
      bit          happens;
      bit          via_index;
      logic [7:0]  store_byte;
      bit          odd_mask;
   } gate_route_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic        csr_data = 1'b0;

   video_memory_access_gate u_dut (.*);

   cfg_type         gate_cfg = 4'b1000;
   logic [7:0]      vram_model    [VRAM_BYTES_DEF];
   logic [7:0]      sprite_model  [SPRITE_BYTES_DEF];
   logic [7:0]      palette_model [PALETTE_BYTES_DEF];
   bit              vram_known    [VRAM_BYTES_DEF];
   bit              sprite_known  [SPRITE_BYTES_DEF];
   bit              palette_known [PALETTE_BYTES_DEF];
   logic [15:0]     vram_slots[$];
   logic [15:0]     sprite_slots[$];
   logic [15:0]     palette_slots[$];

   req_type         pending_requests[$];
   gate_result_type expected_results[$];
   req_type         offered_req;
   int              requests_queued = 0;
   int              requests_accepted = 0;
   int              accepted_by_cmd [8];
   int              stores_taken = 0;
   int              settings_written = 0;
   int              failures = 0;
   int              send_wait = 0;
   int              hold_left = 0;
   int              quiet_cycles = 0;
   int              squeeze_ticket = 0;
   int              squeeze_served = 0;
   bit              sender_pauses = 1'b1;
   bit              receiver_pauses = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [9:0] fold_sprite_slot(logic [9:0] a);
      logic [9:0] f;
      f = a;
      if (f[9]) begin
         f = f & SPR_HIGH_MASK;
      end
      return f;
   endfunction

   function automatic gate_route_type route_access(req_type r, cfg_type c);
      gate_route_type rt;
      logic [8:0]  vis_rd;
      logic [8:0]  vis_wr;
      logic [8:0]  last;
      bit          on;
      rt.target = MEM_NONE;
      rt.slot = 0;
      rt.is_store = 0;
      rt.happens = 0;
      rt.via_index = 0;
      rt.store_byte = r.write_data;
      rt.odd_mask = 0;
      on = !c.display_off;
      vis_rd = c.overscan_mode ? VIS_RD_OVR : VIS_RD_STD;
      vis_wr = c.overscan_mode ? VIS_WR_OVR : VIS_WR_STD;
      last = c.pal_region ? LAST_PAL : LAST_NTSC;
      if (c.interlace_on && !r.odd_field) begin
         last++;
      end
      case (r.command)
         CMD_VRAM_RD: begin
            rt.target = MEM_VRAM;
            rt.slot = 32'(r.address);
            rt.happens = !on || (!(r.line_count == last && r.dot_count == DOT_LAST) &&
               (r.line_count > vis_rd || (r.line_count == vis_rd && r.dot_count == DOT_LAST)));
         end
         CMD_VRAM_WR: begin
            rt.target = MEM_VRAM;
            rt.slot = 32'(r.address);
            rt.is_store = 1;
            if (!on) begin
               rt.happens = 1;
            end else if (r.line_count == 0) begin
               if (r.dot_count <= DOT_EARLY) begin
                  rt.happens = 1;
               end else if (r.dot_count == DOT_LATCH) begin
                  rt.happens = 1;
                  rt.store_byte = r.bus_latch;
               end
            end else if (r.line_count == vis_wr) begin
               rt.happens = r.dot_count > DOT_EARLY;
            end else begin
               rt.happens = r.line_count > vis_wr;
            end
         end
         CMD_SPR_RD, CMD_SPR_WR: begin
            rt.target = MEM_SPRITE;
            rt.via_index = on && r.line_count < vis_wr;
            rt.slot = rt.via_index ? 32'(fold_sprite_slot(r.sprite_index))
                                   : 32'(fold_sprite_slot(r.address[9:0]));
            rt.is_store = r.command == CMD_SPR_WR;
            rt.happens = 1;
         end
         CMD_PAL_RD, CMD_PAL_WR: begin
            rt.target = MEM_PALETTE;
            rt.slot = 32'(r.address[8:0]);
            rt.odd_mask = r.address[0];
            rt.is_store = r.command == CMD_PAL_WR;
            rt.happens = 1;
            if (rt.odd_mask) begin
               rt.store_byte = r.write_data & PAL_ODD_MASK;
            end
         end
         default: ;
      endcase
      return rt;
   endfunction

   function automatic bit slot_known(gate_route_type rt);
      case (rt.target)
         MEM_VRAM:    return vram_known[rt.slot];
         MEM_SPRITE:  return sprite_known[rt.slot];
         MEM_PALETTE: return palette_known[rt.slot];
         default:     return 1'b1;
      endcase
   endfunction

   function automatic void note_store(gate_route_type rt);
      if (!slot_known(rt)) begin
         case (rt.target)
            MEM_VRAM: begin
               vram_known[rt.slot] = 1;
               vram_slots.push_back(16'(rt.slot));
            end
            MEM_SPRITE: begin
               sprite_known[rt.slot] = 1;
               sprite_slots.push_back(16'(rt.slot));
            end
            MEM_PALETTE: begin
               palette_known[rt.slot] = 1;
               palette_slots.push_back(16'(rt.slot));
            end
            default: ;
         endcase
      end
   endfunction

   // Reads are steered onto entries that already hold data; with none yet, the
   // request becomes a write to the same memory.
   function automatic void queue_request(req_type r);
      gate_route_type rt;
      logic [15:0] w;
      rt = route_access(r, gate_cfg);
      if (rt.target != MEM_NONE && !rt.is_store && !slot_known(rt)) begin
         case (rt.target)
            MEM_VRAM: begin
               if (vram_slots.size() == 0) begin
                  r.command = CMD_VRAM_WR;
               end else begin
                  r.address = vram_slots[$urandom_range(0, vram_slots.size() - 1)];
               end
            end
            MEM_SPRITE: begin
               if (sprite_slots.size() == 0) begin
                  r.command = CMD_SPR_WR;
               end else begin
                  w = sprite_slots[$urandom_range(0, sprite_slots.size() - 1)];
                  if (rt.via_index) begin
                     r.sprite_index = w[9:0];
                  end else begin
                     r.address = {6'($urandom),
                        w[9] ? (w[9:0] | (10'($urandom) & 10'h1e0)) : w[9:0]};
                  end
               end
            end
            MEM_PALETTE: begin
               if (palette_slots.size() == 0) begin
                  r.command = CMD_PAL_WR;
               end else begin
                  w = palette_slots[$urandom_range(0, palette_slots.size() - 1)];
                  r.address = {7'($urandom), w[8:0]};
               end
            end
            default: ;
         endcase
         rt = route_access(r, gate_cfg);
      end
      if (rt.is_store && rt.happens) begin
         note_store(rt);
      end
      pending_requests.push_back(r);
      requests_queued++;
   endfunction

   function automatic req_type request_of(logic [2:0] cmd, logic [15:0] addr,
                                          logic [7:0] data, logic [8:0] line,
                                          logic [10:0] dot, logic odd, logic [7:0] latch,
                                          logic [9:0] sidx);
      req_type r;
      r.command = cmd;
      r.address = addr;
      r.write_data = data;
      r.line_count = line;
      r.dot_count = dot;
      r.odd_field = odd;
      r.bus_latch = latch;
      r.sprite_index = sidx;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      if ($urandom_range(0, 19) == 0) begin
         r.command = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_B));
      end else begin
         r.command = 3'($urandom_range(int'(CMD_VRAM_RD), int'(CMD_PAL_WR)));
      end
      r.address = 16'($urandom);
      r.write_data = 8'($urandom);
      r.line_count = $urandom_range(0, 1) ? EDGE_LINES[$urandom_range(0, 13)]
                                          : 9'($urandom_range(0, 511));
      r.dot_count = ($urandom_range(0, 4) < 2) ? EDGE_DOTS[$urandom_range(0, 8)]
                                               : 11'($urandom_range(0, 1363));
      r.odd_field = 1'($urandom);
      r.bus_latch = 8'($urandom);
      r.sprite_index = 10'($urandom_range(0, 543));
      return r;
   endfunction

   function automatic void predict_gate_response(req_type r);
      gate_route_type  rt;
      gate_result_type res;
      rt = route_access(r, gate_cfg);
      res = '0;
      if (rt.happens && rt.is_store) begin
         res.write_taken = 1'b1;
         case (rt.target)
            MEM_VRAM:    vram_model[rt.slot] = rt.store_byte;
            MEM_SPRITE:  sprite_model[rt.slot] = rt.store_byte;
            MEM_PALETTE: palette_model[rt.slot] = rt.store_byte;
            default: ;
         endcase
         stores_taken++;
      end else if (rt.happens) begin
         case (rt.target)
            MEM_VRAM:    res.read_data = vram_model[rt.slot];
            MEM_SPRITE:  res.read_data = sprite_model[rt.slot];
            MEM_PALETTE: res.read_data = palette_model[rt.slot] &
                                         (rt.odd_mask ? PAL_ODD_MASK : 8'hff);
            default: ;
         endcase
      end
      expected_results.push_back(res);
      accepted_by_cmd[r.command]++;
      requests_accepted++;
   endfunction

   always @(posedge clock) begin : drive_requests
      bit offering;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
      end else begin
         offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_gate_response(offered_req);
            offering = 0;
            send_wait = sender_pauses ? $urandom_range(0, 19) : 0;
         end
         if (!offering) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_requests.size() > 0) begin
               offered_req = pending_requests.pop_front();
               offering = 1;
            end
         end
         req_tvalid <= offering;
         req_tdata <= {1'b0, offered_req.sprite_index, offered_req.bus_latch,
                       offered_req.odd_field, offered_req.dot_count, offered_req.line_count,
                       offered_req.write_data, offered_req.address};
         req_tuser <= offered_req.command;
      end
   end

   always @(posedge clock) begin : check_responses
      gate_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("Response with no request waiting: read_data %0h, write_taken %0b",
                      rsp_tdata, rsp_tuser[0]);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.read_data) begin
                  $error("read_data: expected %0h, actual %0h", want.read_data, rsp_tdata);
                  failures++;
               end
               if (rsp_tuser[0] !== want.write_taken) begin
                  $error("write_taken: expected %0b, actual %0b",
                         want.write_taken, rsp_tuser[0]);
                  failures++;
               end
            end
            hold_left = receiver_pauses ? $urandom_range(0, 19) : 0;
         end
         if (squeeze_served != squeeze_ticket) begin
            hold_left = SQUEEZE_CYCLES;
            squeeze_served = squeeze_ticket;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic wait_until_idle();
      while (requests_accepted != requests_queued || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(cfg_type c);
      logic vals [4];
      vals = '{c.display_off, c.overscan_mode, c.pal_region, c.interlace_on};
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(k);
         csr_data <= vals[k];
         do @(posedge clock); while (!csr_ready);
         case (csr_index_type'(k))
            CSR_DISPLAY_OFF:   gate_cfg.display_off = vals[k];
            CSR_OVERSCAN_MODE: gate_cfg.overscan_mode = vals[k];
            CSR_PAL_REGION:    gate_cfg.pal_region = vals[k];
            CSR_INTERLACE_ON:  gate_cfg.interlace_on = vals[k];
            default: ;
         endcase
         settings_written++;
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : run_test
      cfg_type phase_cfg;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Forced blank after reset: every access goes straight through.
      queue_request(request_of(CMD_VRAM_WR, 16'h0000, 8'hff, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_VRAM_WR, 16'hffff, 8'h00, 9'd511, 11'd1363, 1'b1, 8'hff,
                               10'd543));
      queue_request(request_of(CMD_VRAM_RD, 16'hffff, 8'h00, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_SPR_WR, 16'hffff, 8'h5a, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_SPR_WR, 16'h0000, 8'hff, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_SPR_RD, 16'h021f, 8'h00, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_PAL_WR, 16'h0001, 8'hff, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_PAL_WR, 16'hfffe, 8'hff, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_PAL_RD, 16'h0201, 8'h00, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_PAL_RD, 16'h01fe, 8'h00, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_SPARE_A, 16'h0000, 8'h00, 9'd0, 11'd0, 1'b0, 8'h00,
                               10'd0));
      queue_request(request_of(CMD_SPARE_B, 16'hffff, 8'hff, 9'd0, 11'd0, 1'b0, 8'hff,
                               10'd0));
      wait_until_idle();

      // Display on: write windows around line 0 and the first line after the
      // visible area, read windows around the last visible line and the last line.
      apply_settings(4'b0000);
      queue_request(request_of(CMD_VRAM_WR, 16'h0010, 8'h11, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_VRAM_WR, 16'h0011, 8'h22, 9'd0, 11'd4, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_VRAM_WR, 16'h0012, 8'h33, 9'd0, 11'd5, 1'b0, 8'h00, 10'd0));
      queue_request(request_of(CMD_VRAM_WR, 16'h0013, 8'h44, 9'd0, 11'd6, 1'b0, 8'ha5, 10'd0));
      queue_request(request_of(CMD_VRAM_WR, 16'h0014, 8'h55, 9'd100, 11'd9, 1'b0, 8'h00,
                               10'd0));
      queue_request(request_of(CMD_VRAM_WR, 16'h0015, 8'h66, 9'd225, 11'd4, 1'b0, 8'h00,
                               10'd0));
      queue_request(request_of(CMD_VRAM_WR, 16'h0016, 8'h77, 9'd225, 11'd5, 1'b0, 8'h00,
                               10'd0));
      queue_request(request_of(CMD_VRAM_RD, 16'h0013, 8'h00, 9'd224, 11'd1361, 1'b0, 8'h00,
                               10'd0));
      queue_request(request_of(CMD_VRAM_RD, 16'h0013, 8'h00, 9'd224, 11'd1362, 1'b0, 8'h00,
                               10'd0));
      queue_request(request_of(CMD_VRAM_RD, 16'h0016, 8'h00, 9'd261, 11'd1362, 1'b1, 8'h00,
                               10'd0));
      queue_request(request_of(CMD_VRAM_RD, 16'h0016, 8'h00, 9'd262, 11'd1362, 1'b1, 8'h00,
                               10'd0));
      queue_request(request_of(CMD_SPR_WR, 16'h0000, 8'hc3, 9'd10, 11'd0, 1'b0, 8'h00,
                               10'd543));
      queue_request(request_of(CMD_SPR_RD, 16'h0000, 8'h00, 9'd10, 11'd0, 1'b0, 8'h00,
                               10'd543));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_until_idle();
         phase_cfg = (p < 8) ? SETTING_PLAN[p] : cfg_type'($urandom_range(0, 15));
         apply_settings(phase_cfg);
         sender_pauses = (p % 4) != 0;
         receiver_pauses = (p % 4) != 0 && (p % 4) != 2;
         if (p == 2) begin
            sender_pauses = 0;
            squeeze_ticket++;
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            queue_request(random_request());
         end
      end
      wait_until_idle();
      repeat (6) @(posedge clock);

      $display("Covered %0d requests under %0d settings writes, %0d of them stores taken.",
               requests_accepted, settings_written, stores_taken);
      $display("By command: vram %0d/%0d, sprite %0d/%0d, palette %0d/%0d, unused %0d.",
               accepted_by_cmd[CMD_VRAM_RD], accepted_by_cmd[CMD_VRAM_WR],
               accepted_by_cmd[CMD_SPR_RD], accepted_by_cmd[CMD_SPR_WR],
               accepted_by_cmd[CMD_PAL_RD], accepted_by_cmd[CMD_PAL_WR],
               accepted_by_cmd[CMD_SPARE_A] + accepted_by_cmd[CMD_SPARE_B]);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: video_memory_access_gate.f
+incdir+rtl
rtl/vmag_pkg.sv
rtl/vmag_ram.sv
rtl/vmag_gate.sv
rtl/video_memory_access_gate.sv
tb/tb_video_memory_access_gate.sv
